// File: rtl/ppe_pkg.sv
`default_nettype none
package ppe_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int VAL_W       = 32;
	localparam int WIDE_W      = 48;
	localparam int PROD_W      = 2 * WIDE_W;
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int DVS_W       = 33;
	localparam int IN_TDATA_W  = 288;
	localparam int OUT_TDATA_W = 240;

	localparam logic [5:0] MUL_STEPS  = 6'(WIDE_W);
	localparam logic [5:0] SQRT_STEPS = 6'(ROOT_W);
	localparam logic [6:0] DIV_STEPS  = 7'(RAD_W);

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_HEADER = 3'd1;
	localparam logic [2:0] OP_VEL    = 3'd2;
	localparam logic [2:0] OP_BOND   = 3'd3;
	localparam logic [2:0] OP_FINISH = 3'd4;

	localparam logic [1:0] REG_BULK    = 2'd0;
	localparam logic [1:0] REG_SHEAR   = 2'd1;
	localparam logic [1:0] REG_DENSITY = 2'd2;

	localparam logic [31:0] MOD_RESET = 32'h0001_0000;
	localparam logic [47:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MIN   = 48'h8000_0000_0000;
	localparam logic [DVS_W-1:0] DIV_BY_THREE = 33'd3;

	typedef struct packed {
		logic [47:0] val;
		logic        ovf;
	} sat_t;

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? 32'(32'd0 - v) : v;
	endfunction

	function automatic logic [47:0] mag48(input logic [47:0] v);
		return v[47] ? 48'(48'd0 - v) : v;
	endfunction

	// shift product right, truncate magnitude, apply sign, clamp to 48 bits
	function automatic sat_t sat_prod(input logic [PROD_W-1:0] p, input logic neg,
			input logic one_more);
		logic [PROD_W-1:0] r;
		sat_t s;
		r = one_more ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
		if (neg) begin
			if ((|r[PROD_W-1:48]) || (r[47] && (|r[46:0]))) begin
				s.val = NEG_MIN;
				s.ovf = 1'b1;
			end else begin
				s.val = 48'(48'd0 - r[47:0]);
				s.ovf = 1'b0;
			end
		end else if (|r[PROD_W-1:47]) begin
			s.val = POS_MAX;
			s.ovf = 1'b1;
		end else begin
			s.val = r[47:0];
			s.ovf = 1'b0;
		end
		return s;
	endfunction

	function automatic sat_t sat48(input logic [49:0] v);
		sat_t s;
		if (!v[49] && (|v[48:47])) begin
			s.val = POS_MAX;
			s.ovf = 1'b1;
		end else if (v[49] && !(&v[48:47])) begin
			s.val = NEG_MIN;
			s.ovf = 1'b1;
		end else begin
			s.val = v[47:0];
			s.ovf = 1'b0;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// File: rtl/peridynamic_point_energy.sv
// channel   | direction | handshake              | payload
// s_*       | in        | s_tvalid / s_tready    | s_tuser operation, s_tdata point fields
// m_*       | out       | m_tvalid / m_tready    | m_tdata energies and overflow flag
// cfg_*     | in        | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Clear, header and unused words complete on acceptance. The shared shift-add
// multiplier serves all products; a velocity word takes three multiplies, a
// bond eight (with two roots and one divide) and finish six and one divide
// (five multiplies and no divide with zero weight).
// Reset clears all state and loads the three registers with 1.0. Input stalls
// while a word is in progress and while a finished result waits on an unread one.
`default_nettype none
module peridynamic_point_energy (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// volume, weight, dilatation, vec_a_x/y/z, vec_b_x/y/z
	input  wire logic [ppe_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation
	input  wire logic [2:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// energy_density, point strain, point kinetic, strain total,
	// kinetic total, overflow
	output logic      [ppe_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [31:0]                        cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_VEL, ST_VEL_W, ST_SQ, ST_SQ_W, ST_RT, ST_RT_W, ST_TX, ST_TX_W,
		ST_D3, ST_D3_W, ST_TV, ST_TV_W, ST_TH, ST_TH_W, ST_BK, ST_BK_W, ST_Q, ST_Q_W,
		ST_DV, ST_DV_W, ST_DN, ST_SE, ST_SE_W, ST_T, ST_T_W, ST_KE, ST_KE_W, ST_OUT
	} state_t;

	state_t       state_q;
	logic [1:0]   k_q;
	logic         vsel_q;
	logic         ovf_q;
	logic [31:0]  bulk_mod_q;
	logic [31:0]  shear_mod_q;
	logic [31:0]  rho_q;
	logic [31:0]  ref_q [3];
	logic [31:0]  cur_q [3];
	logic [30:0]  own_vol_q;
	logic [30:0]  own_wt_q;
	logic [31:0]  own_dil_q;
	logic [47:0]  ss_q;
	logic [47:0]  acc_q;
	logic [47:0]  st_q;
	logic [46:0]  kt_q;
	logic [31:0]  a_q [3];
	logic [31:0]  b_q [3];
	logic [30:0]  vol_q;
	logic [31:0]  x_q;
	logic [31:0]  y_q;
	logic [63:0]  sum_q;
	logic [47:0]  r1_q;
	logic [47:0]  bulk_q;
	logic [47:0]  dens_q;
	logic [47:0]  se_q;
	logic [46:0]  ke_q;
	logic         m_tvalid_q;
	logic [ppe_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [2:0]   in_op;
	logic [30:0]  in_vol;
	logic [30:0]  in_wt;
	logic [31:0]  in_dil;
	logic [31:0]  in_a [3];
	logic [31:0]  in_b [3];

	logic [31:0]  far_v;
	logic [31:0]  near_v;
	logic [32:0]  diff;
	logic [31:0]  dsat;
	logic         dovf;
	logic [35:0]  mu15;

	logic                          mul_start;
	logic [ppe_pkg::WIDE_W-1:0]    mul_a;
	logic [ppe_pkg::WIDE_W-1:0]    mul_b;
	logic                          mul_done;
	logic [ppe_pkg::PROD_W-1:0]    mul_prod;
	logic                          sqrt_start;
	logic                          sqrt_done;
	logic [ppe_pkg::ROOT_W-1:0]    sqrt_root;
	logic                          div_start;
	logic [ppe_pkg::RAD_W-1:0]     div_n;
	logic [ppe_pkg::DVS_W-1:0]     div_d;
	logic                          div_done;
	logic [ppe_pkg::RAD_W-1:0]     div_q;

	logic          neg_w;
	logic          one_more_w;
	ppe_pkg::sat_t mres;
	ppe_pkg::sat_t term;
	ppe_pkg::sat_t accs;
	ppe_pkg::sat_t dsum;
	ppe_pkg::sat_t stsum;
	logic [47:0]   tx;
	logic [47:0]   quo48;
	logic [47:0]   shear;
	logic [47:0]   ktsum;

	assign in_op    = s_tuser;
	assign in_vol   = s_tdata[30:0];
	assign in_wt    = s_tdata[61:31];
	assign in_dil   = s_tdata[93:62];
	assign in_a[0]  = s_tdata[125:94];
	assign in_a[1]  = s_tdata[157:126];
	assign in_a[2]  = s_tdata[189:158];
	assign in_b[0]  = s_tdata[221:190];
	assign in_b[1]  = s_tdata[253:222];
	assign in_b[2]  = s_tdata[285:254];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign far_v  = vsel_q ? b_q[k_q] : a_q[k_q];
	assign near_v = vsel_q ? cur_q[k_q] : ref_q[k_q];
	assign diff   = {far_v[31], far_v} - {near_v[31], near_v};
	assign dovf   = diff[32] != diff[31];
	assign dsat   = !dovf ? diff[31:0] : (diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	assign mu15   = {shear_mod_q, 4'b0000} - {4'b0000, shear_mod_q};

	always_comb begin
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_n      = '0;
		div_d      = ppe_pkg::DIV_BY_THREE;
		unique case (state_q)
			ST_VEL: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, ppe_pkg::abs32(a_q[k_q])};
				mul_b     = {16'd0, ppe_pkg::abs32(a_q[k_q])};
			end
			ST_SQ: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, ppe_pkg::abs32(dsat)};
				mul_b     = {16'd0, ppe_pkg::abs32(dsat)};
			end
			ST_RT: sqrt_start = 1'b1;
			ST_TX: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, ppe_pkg::abs32(own_dil_q)};
				mul_b     = {16'd0, x_q};
			end
			ST_D3: begin
				div_start = 1'b1;
				div_n     = {16'd0, ppe_pkg::mag48(r1_q)};
			end
			ST_TV: begin
				mul_start = 1'b1;
				mul_a     = ppe_pkg::mag48(r1_q);
				mul_b     = {17'd0, vol_q};
			end
			ST_TH: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, ppe_pkg::abs32(own_dil_q)};
				mul_b     = {16'd0, ppe_pkg::abs32(own_dil_q)};
			end
			ST_BK: begin
				mul_start = 1'b1;
				mul_a     = r1_q;
				mul_b     = {16'd0, bulk_mod_q};
			end
			ST_Q: begin
				mul_start = 1'b1;
				mul_a     = ppe_pkg::mag48(acc_q);
				mul_b     = {12'd0, mu15};
			end
			ST_DV: begin
				div_start = 1'b1;
				div_n     = 64'(ppe_pkg::mag48(r1_q)) << ppe_pkg::FRAC_BITS;
				div_d     = {1'b0, own_wt_q, 1'b0};
			end
			ST_SE: begin
				mul_start = 1'b1;
				mul_a     = ppe_pkg::mag48(dens_q);
				mul_b     = {17'd0, own_vol_q};
			end
			ST_T: begin
				mul_start = 1'b1;
				mul_a     = {16'd0, rho_q};
				mul_b     = {17'd0, own_vol_q};
			end
			ST_KE: begin
				mul_start = 1'b1;
				mul_a     = r1_q;
				mul_b     = ss_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		neg_w      = 1'b0;
		one_more_w = 1'b0;
		unique case (state_q)
			ST_TX_W: neg_w      = own_dil_q[31];
			ST_TV_W: neg_w      = r1_q[47];
			ST_Q_W:  neg_w      = acc_q[47];
			ST_SE_W: neg_w      = dens_q[47];
			ST_BK_W: one_more_w = 1'b1;
			ST_KE_W: one_more_w = 1'b1;
			default: ;
		endcase
	end

	assign mres  = ppe_pkg::sat_prod(mul_prod, neg_w, one_more_w);
	assign tx    = r1_q[47] ? 48'(48'd0 - div_q[47:0]) : div_q[47:0];
	assign term  = ppe_pkg::sat48(50'({18'd0, y_q}) - 50'({18'd0, x_q})
		- {{2{tx[47]}}, tx});
	assign accs  = ppe_pkg::sat48({{2{acc_q[47]}}, acc_q} + {{2{mres.val[47]}}, mres.val});
	assign quo48 = (|div_q[63:47]) ? 48'(ppe_pkg::POS_MAX + 48'(r1_q[47])) : div_q[47:0];
	assign shear = r1_q[47] ? 48'(48'd0 - quo48) : quo48;
	assign dsum  = ppe_pkg::sat48({{2{bulk_q[47]}}, bulk_q} + {{2{r1_q[47]}}, r1_q});
	assign stsum = ppe_pkg::sat48({{2{st_q[47]}}, st_q} + {{2{se_q[47]}}, se_q});
	assign ktsum = {1'b0, kt_q} + {1'b0, mres.val[46:0]};

	ppe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ppe_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	ppe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			vsel_q      <= 1'b0;
			ovf_q       <= 1'b0;
			bulk_mod_q  <= ppe_pkg::MOD_RESET;
			shear_mod_q <= ppe_pkg::MOD_RESET;
			rho_q       <= ppe_pkg::MOD_RESET;
			for (int i = 0; i < 3; i++) begin
				ref_q[i] <= '0;
				cur_q[i] <= '0;
				a_q[i]   <= '0;
				b_q[i]   <= '0;
			end
			own_vol_q  <= '0;
			own_wt_q   <= '0;
			own_dil_q  <= '0;
			ss_q       <= '0;
			acc_q      <= '0;
			st_q       <= '0;
			kt_q       <= '0;
			vol_q      <= '0;
			x_q        <= '0;
			y_q        <= '0;
			sum_q      <= '0;
			r1_q       <= '0;
			bulk_q     <= '0;
			dens_q     <= '0;
			se_q       <= '0;
			ke_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ppe_pkg::REG_BULK:    bulk_mod_q  <= cfg_data;
					ppe_pkg::REG_SHEAR:   shear_mod_q <= cfg_data;
					ppe_pkg::REG_DENSITY: rho_q       <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						for (int i = 0; i < 3; i++) begin
							a_q[i] <= in_a[i];
							b_q[i] <= in_b[i];
						end
						vol_q <= in_vol;
						unique case (in_op)
							ppe_pkg::OP_CLEAR: begin
								st_q  <= '0;
								kt_q  <= '0;
								ovf_q <= 1'b0;
							end
							ppe_pkg::OP_HEADER: begin
								own_vol_q <= in_vol;
								own_wt_q  <= in_wt;
								own_dil_q <= in_dil;
								for (int i = 0; i < 3; i++) begin
									ref_q[i] <= in_a[i];
									cur_q[i] <= in_b[i];
								end
								acc_q <= '0;
								ss_q  <= '0;
							end
							ppe_pkg::OP_VEL: begin
								ss_q    <= '0;
								k_q     <= '0;
								state_q <= ST_VEL;
							end
							ppe_pkg::OP_BOND: begin
								sum_q   <= '0;
								k_q     <= '0;
								vsel_q  <= 1'b0;
								state_q <= ST_SQ;
							end
							ppe_pkg::OP_FINISH: state_q <= ST_TH;
							default: ;
						endcase
					end
				end
				ST_VEL: state_q <= ST_VEL_W;
				ST_VEL_W: begin
					if (mul_done) begin
						ss_q <= ss_q + 48'(mul_prod >> ppe_pkg::FRAC_BITS);
						if (k_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_VEL;
						end
					end
				end
				ST_SQ: begin
					ovf_q   <= ovf_q | dovf;
					state_q <= ST_SQ_W;
				end
				ST_SQ_W: begin
					if (mul_done) begin
						sum_q <= sum_q + mul_prod[63:0];
						if (k_q == 2'd2) begin
							state_q <= ST_RT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_SQ;
						end
					end
				end
				ST_RT: state_q <= ST_RT_W;
				ST_RT_W: begin
					if (sqrt_done) begin
						if (!vsel_q) begin
							x_q     <= sqrt_root;
							vsel_q  <= 1'b1;
							k_q     <= '0;
							sum_q   <= '0;
							state_q <= ST_SQ;
						end else begin
							y_q     <= sqrt_root;
							state_q <= ST_TX;
						end
					end
				end
				ST_TX: state_q <= ST_TX_W;
				ST_TX_W: begin
					if (mul_done) begin
						r1_q    <= mres.val;
						ovf_q   <= ovf_q | mres.ovf;
						state_q <= ST_D3;
					end
				end
				ST_D3: state_q <= ST_D3_W;
				ST_D3_W: begin
					if (div_done) begin
						r1_q    <= term.val;
						ovf_q   <= ovf_q | term.ovf;
						state_q <= ST_TV;
					end
				end
				ST_TV: state_q <= ST_TV_W;
				ST_TV_W: begin
					if (mul_done) begin
						acc_q   <= accs.val;
						ovf_q   <= ovf_q | mres.ovf | accs.ovf;
						state_q <= ST_IDLE;
					end
				end
				ST_TH: state_q <= ST_TH_W;
				ST_TH_W: begin
					if (mul_done) begin
						r1_q    <= mres.val;
						ovf_q   <= ovf_q | mres.ovf;
						state_q <= ST_BK;
					end
				end
				ST_BK: state_q <= ST_BK_W;
				ST_BK_W: begin
					if (mul_done) begin
						bulk_q <= mres.val;
						ovf_q  <= ovf_q | mres.ovf | (own_wt_q == '0);
						if (own_wt_q == '0) begin
							r1_q    <= '0;
							state_q <= ST_DN;
						end else begin
							state_q <= ST_Q;
						end
					end
				end
				ST_Q: state_q <= ST_Q_W;
				ST_Q_W: begin
					if (mul_done) begin
						r1_q    <= mres.val;
						ovf_q   <= ovf_q | mres.ovf;
						state_q <= ST_DV;
					end
				end
				ST_DV: state_q <= ST_DV_W;
				ST_DV_W: begin
					if (div_done) begin
						r1_q    <= shear;
						state_q <= ST_DN;
					end
				end
				ST_DN: begin
					dens_q  <= dsum.val;
					ovf_q   <= ovf_q | dsum.ovf;
					state_q <= ST_SE;
				end
				ST_SE: state_q <= ST_SE_W;
				ST_SE_W: begin
					if (mul_done) begin
						se_q    <= mres.val;
						ovf_q   <= ovf_q | mres.ovf;
						state_q <= ST_T;
					end
				end
				ST_T: state_q <= ST_T_W;
				ST_T_W: begin
					if (mul_done) begin
						r1_q    <= mres.val;
						ovf_q   <= ovf_q | mres.ovf;
						state_q <= ST_KE;
					end
				end
				ST_KE: state_q <= ST_KE_W;
				ST_KE_W: begin
					if (mul_done) begin
						ke_q  <= mres.val[46:0];
						st_q  <= stsum.val;
						kt_q  <= ktsum[47] ? ppe_pkg::POS_MAX[46:0] : ktsum[46:0];
						ovf_q <= ovf_q | mres.ovf | stsum.ovf | ktsum[47];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {1'b0, ovf_q, kt_q, st_q, ke_q, se_q, dens_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppe_mul.sv
`default_nettype none
module ppe_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ppe_pkg::WIDE_W-1:0]    a,
	input  wire logic [ppe_pkg::WIDE_W-1:0]    b,
	output logic                               done,
	output logic      [ppe_pkg::PROD_W-1:0]    prod
);

	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [ppe_pkg::WIDE_W-1:0]   a_q;
	logic [ppe_pkg::WIDE_W-1:0]   hi_q;
	logic [ppe_pkg::WIDE_W-1:0]   lo_q;
	logic [ppe_pkg::WIDE_W:0]     sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= ppe_pkg::MUL_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[ppe_pkg::WIDE_W:1];
			lo_q <= {sum[0], lo_q[ppe_pkg::WIDE_W-1:1]};
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppe_sqrt.sv
`default_nettype none
module ppe_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ppe_pkg::RAD_W-1:0]    rad,
	output logic                              done,
	output logic      [ppe_pkg::ROOT_W-1:0]   root
);

	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [ppe_pkg::RAD_W-1:0]    rad_q;
	logic [ppe_pkg::ROOT_W+1:0]   rem_q;
	logic [ppe_pkg::ROOT_W-1:0]   root_q;
	logic [ppe_pkg::ROOT_W+3:0]   remx;
	logic [ppe_pkg::ROOT_W+3:0]   trial;

	assign remx  = {rem_q, rad_q[ppe_pkg::RAD_W-1:ppe_pkg::RAD_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= ppe_pkg::SQRT_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one root bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[ppe_pkg::RAD_W-3:0], 2'b00};
			if (remx >= trial) begin
				rem_q  <= (ppe_pkg::ROOT_W+2)'(remx - trial);
				root_q <= {root_q[ppe_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= remx[ppe_pkg::ROOT_W+1:0];
				root_q <= {root_q[ppe_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppe_div.sv
`default_nettype none
module ppe_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ppe_pkg::RAD_W-1:0]    dividend,
	input  wire logic [ppe_pkg::DVS_W-1:0]    divisor,
	output logic                              done,
	output logic      [ppe_pkg::RAD_W-1:0]    quotient
);

	logic [6:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ppe_pkg::RAD_W-1:0]   quo_q;
	logic [ppe_pkg::DVS_W-1:0]   rem_q;
	logic [ppe_pkg::DVS_W-1:0]   dvs_q;
	logic [ppe_pkg::DVS_W:0]     remx;

	assign remx     = {rem_q, quo_q[ppe_pkg::RAD_W-1]};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= ppe_pkg::DIV_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (remx >= {1'b0, dvs_q}) begin
				rem_q <= ppe_pkg::DVS_W'(remx - {1'b0, dvs_q});
				quo_q <= {quo_q[ppe_pkg::RAD_W-2:0], 1'b1};
			end else begin
				rem_q <= remx[ppe_pkg::DVS_W-1:0];
				quo_q <= {quo_q[ppe_pkg::RAD_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppe_check.sv
`default_nettype none
module ppe_check (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [2:0]                       s_tuser,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [ppe_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ppe_pkg::OP_FINISH |=> !s_tready)
		else $error("finish word did not start computation");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ppe_pkg::OP_CLEAR |=> s_tready)
		else $error("clear word not done in one cycle");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[237:191] >= m_tdata[142:96])
		else $error("kinetic total below point kinetic energy");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without computation");

endmodule

bind peridynamic_point_energy ppe_check u_ppe_check (.*);
`default_nettype wire

// File: verif/peridynamic_point_energy_test.sv
`timescale 1ns / 1ps
module peridynamic_point_energy_test;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -64'sh8000_0000_0000;

	typedef struct packed {
		logic [2:0]       op;
		logic [30:0]      vol;
		logic [30:0]      wvol;
		logic [31:0]      dil;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
	} point_word_t;

	typedef struct packed {
		logic [47:0] density;
		logic [47:0] strain;
		logic [46:0] kinetic;
		logic [47:0] strain_sum;
		logic [46:0] kinetic_sum;
		logic        ovf;
	} energy_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ppe_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic [2:0] s_tuser = ppe_pkg::OP_CLEAR;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ppe_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = ppe_pkg::REG_BULK;
	logic [31:0] cfg_data = '0;

	peridynamic_point_energy dut (.*);

	point_word_t pending_words[$];
	energy_t expected_energy[$];
	point_word_t cur_word;
	int send_idle_pct = 24;
	int recv_idle_pct = 49;
	int errors = 0;
	int results_seen = 0;
	int hold_left = 0;

	logic [31:0] bulk_k, shear_mu, density_rho;
	logic signed [63:0] ref_pos[3], cur_pos[3];
	logic signed [63:0] pt_volume, pt_weight, pt_theta;
	logic signed [63:0] v_sq, bond_sum, strain_acc, kinetic_acc;
	logic ovf_flag;

	initial forever #1 clk = ~clk;

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic queue_word(input point_word_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
		if (v > SAT_HI) begin
			ovf_flag = 1'b1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			ovf_flag = 1'b1;
			return SAT_LO;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) begin
			ovf_flag = 1'b1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			ovf_flag = 1'b1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] x,
			input logic signed [63:0] y, input int sh);
		logic neg;
		logic [63:0] ux, uy;
		logic [127:0] p;
		neg = (x < 0) != (y < 0);
		ux = x < 0 ? 64'(-x) : 64'(x);
		uy = y < 0 ? 64'(-y) : 64'(y);
		p = {64'd0, ux} * {64'd0, uy};
		p = p >> sh;
		if (neg) begin
			if (p > 128'h8000_0000_0000) begin
				ovf_flag = 1'b1;
				return SAT_LO;
			end
			return -$signed(p[63:0]);
		end
		if (p > 128'h7FFF_FFFF_FFFF) begin
			ovf_flag = 1'b1;
			return SAT_HI;
		end
		return $signed(p[63:0]);
	endfunction

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else
				res = res >> 1;
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] bond_length(input logic [2:0][31:0] far_pt,
			input logic signed [63:0] near_pt[3]);
		logic [63:0] sum, u;
		logic signed [63:0] d;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			d = clamp32(64'($signed(far_pt[k])) - near_pt[k]);
			u = d < 0 ? 64'(-d) : 64'(d);
			sum = sum + u * u;
		end
		return $signed(int_root(sum));
	endfunction

	task automatic predict_word(input point_word_t w);
		logic signed [63:0] x, y, tx, term, bulk, shear, q, dens, se, ke;
		logic [63:0] mag, quo;
		energy_t e;
		case (w.op)
			ppe_pkg::OP_CLEAR: begin
				strain_acc = 0;
				kinetic_acc = 0;
				ovf_flag = 1'b0;
			end
			ppe_pkg::OP_HEADER: begin
				pt_volume = 64'(w.vol);
				pt_weight = 64'(w.wvol);
				pt_theta = 64'($signed(w.dil));
				for (int k = 0; k < 3; k++) begin
					ref_pos[k] = 64'($signed(w.a[k]));
					cur_pos[k] = 64'($signed(w.b[k]));
				end
				bond_sum = 0;
				v_sq = 0;
			end
			ppe_pkg::OP_VEL: begin
				v_sq = 0;
				for (int k = 0; k < 3; k++)
					v_sq = v_sq + ((64'($signed(w.a[k])) * 64'($signed(w.a[k])))
						>>> ppe_pkg::FRAC_BITS);
			end
			ppe_pkg::OP_BOND: begin
				x = bond_length(w.a, ref_pos);
				y = bond_length(w.b, cur_pos);
				tx = scaled_mul(pt_theta, x, ppe_pkg::FRAC_BITS) / 3;
				term = clamp48((y - x) - tx);
				term = scaled_mul(term, 64'(w.vol), ppe_pkg::FRAC_BITS);
				bond_sum = clamp48(bond_sum + term);
			end
			ppe_pkg::OP_FINISH: begin
				bulk = scaled_mul(64'(bulk_k),
					scaled_mul(pt_theta, pt_theta, ppe_pkg::FRAC_BITS),
					ppe_pkg::FRAC_BITS + 1);
				shear = 0;
				if (pt_weight == 0)
					ovf_flag = 1'b1;
				else begin
					q = scaled_mul(64'(shear_mu) * 15, bond_sum, ppe_pkg::FRAC_BITS);
					mag = q < 0 ? 64'(-q) : 64'(q);
					quo = (mag << ppe_pkg::FRAC_BITS) / (64'(pt_weight) * 2);
					if (quo > 64'(SAT_HI))
						quo = 64'(SAT_HI) + (q < 0 ? 64'd1 : 64'd0);
					shear = q < 0 ? -$signed(quo) : $signed(quo);
					shear = clamp48(shear);
				end
				dens = clamp48(bulk + shear);
				se = scaled_mul(pt_volume, dens, ppe_pkg::FRAC_BITS);
				ke = scaled_mul(scaled_mul(pt_volume, 64'(density_rho), ppe_pkg::FRAC_BITS),
					v_sq, ppe_pkg::FRAC_BITS + 1);
				strain_acc = clamp48(strain_acc + se);
				kinetic_acc = clamp48(kinetic_acc + ke);
				e.density = dens[47:0];
				e.strain = se[47:0];
				e.kinetic = ke[46:0];
				e.strain_sum = strain_acc[47:0];
				e.kinetic_sum = kinetic_acc[46:0];
				e.ovf = ovf_flag;
				expected_energy.insert(expected_energy.size(), e);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_word(cur_word);
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_word.b, cur_word.a, cur_word.dil,
						cur_word.wvol, cur_word.vol};
					s_tuser <= cur_word.op;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		energy_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.density = m_tdata[47:0];
				got.strain = m_tdata[95:48];
				got.kinetic = m_tdata[142:96];
				got.strain_sum = m_tdata[190:143];
				got.kinetic_sum = m_tdata[237:191];
				got.ovf = m_tdata[238];
				results_seen++;
				if (results_seen == 15)
					hold_left = 4000;
				if (expected_energy.size() == 0) begin
					errors++;
					$display("%t unexpected result %h", $realtime, got);
				end else begin
					want = expected_energy.pop_front();
					if (got.density !== want.density) begin
						errors++;
						$display("%t energy_density exp %h got %h", $realtime,
							want.density, got.density);
					end
					if (got.strain !== want.strain) begin
						errors++;
						$display("%t point strain exp %h got %h", $realtime,
							want.strain, got.strain);
					end
					if (got.kinetic !== want.kinetic) begin
						errors++;
						$display("%t point kinetic exp %h got %h", $realtime,
							want.kinetic, got.kinetic);
					end
					if (got.strain_sum !== want.strain_sum) begin
						errors++;
						$display("%t strain total exp %h got %h", $realtime,
							want.strain_sum, got.strain_sum);
					end
					if (got.kinetic_sum !== want.kinetic_sum) begin
						errors++;
						$display("%t kinetic total exp %h got %h", $realtime,
							want.kinetic_sum, got.kinetic_sum);
					end
					if (got.ovf !== want.ovf) begin
						errors++;
						$display("%t overflow exp %b got %b", $realtime, want.ovf, got.ovf);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ppe_pkg::REG_BULK: bulk_k = val;
			ppe_pkg::REG_SHEAR: shear_mu = val;
			default: density_rho = val;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_and_settle();
		do @(posedge clk); while (pending_words.size() > 0 || s_tvalid ||
			expected_energy.size() > 0);
		repeat (700) @(posedge clk);
	endtask

	function automatic logic [31:0] coord(input logic [31:0] base);
		if ($urandom_range(7) == 0)
			return $urandom;
		return base + 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
	endfunction

	function automatic logic [30:0] amount();
		case ($urandom_range(7))
			0: return '0;
			1: return 31'($urandom);
			default: return 31'($urandom_range(32'h0004_0000));
		endcase
	endfunction

	function automatic point_word_t noise_word();
		logic [319:0] raw;
		point_word_t w;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		w = raw[$bits(point_word_t)-1:0];
		return w;
	endfunction

	task automatic add_point(output int added);
		point_word_t hdr, w;
		int nb;
		added = 0;
		if ($urandom_range(5) == 0) begin
			w = noise_word();
			w.op = ppe_pkg::OP_CLEAR;
			queue_word(w);
			added++;
		end
		hdr = noise_word();
		hdr.op = ppe_pkg::OP_HEADER;
		hdr.vol = amount();
		hdr.wvol = $urandom_range(9) == 0 ? amount() : 31'($urandom_range(1, 32'h0040_0000));
		hdr.dil = $urandom_range(7) == 0 ? $urandom :
			32'($urandom_range(32'h0001_0000)) - 32'h8000;
		for (int k = 0; k < 3; k++) begin
			hdr.a[k] = coord(32'($urandom_range(32'h0100_0000)) - 32'h0080_0000);
			hdr.b[k] = coord(hdr.a[k]);
		end
		queue_word(hdr);
		added++;
		if ($urandom_range(3) != 0) begin
			w = noise_word();
			w.op = ppe_pkg::OP_VEL;
			for (int k = 0; k < 3; k++)
				w.a[k] = $urandom_range(7) == 0 ? $urandom :
					32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
			queue_word(w);
			added++;
		end
		nb = $urandom_range(4);
		for (int i = 0; i < nb; i++) begin
			w = noise_word();
			w.op = ppe_pkg::OP_BOND;
			w.vol = amount();
			for (int k = 0; k < 3; k++) begin
				w.a[k] = coord(hdr.a[k]);
				w.b[k] = coord(hdr.b[k]);
			end
			queue_word(w);
			added++;
		end
		if ($urandom_range(9) != 0) begin
			w = noise_word();
			w.op = ppe_pkg::OP_FINISH;
			queue_word(w);
			added++;
		end
	endtask

	task automatic add_directed();
		point_word_t w;
		w = '0;
		w.op = ppe_pkg::OP_CLEAR;
		queue_word(w);
		w.op = ppe_pkg::OP_HEADER;
		w.vol = '1;
		w.wvol = '1;
		w.dil = 32'h8000_0000;
		queue_word(w);
		w = '0;
		w.op = ppe_pkg::OP_VEL;
		w.a = {3{32'h8000_0000}};
		queue_word(w);
		w = '0;
		w.op = ppe_pkg::OP_BOND;
		w.vol = '1;
		w.a = {3{32'h7FFF_FFFF}};
		w.b = {3{32'h8000_0000}};
		queue_word(w);
		w = noise_word();
		w.op = ppe_pkg::OP_FINISH;
		queue_word(w);
		w = noise_word();
		w.op = ppe_pkg::OP_HEADER;
		w.vol = 31'h0001_0000;
		w.wvol = '0;
		w.dil = 32'h7FFF_FFFF;
		queue_word(w);
		w.op = ppe_pkg::OP_BOND;
		w.a[0] = w.a[0] + 32'h0001_0000;
		queue_word(w);
		w = noise_word();
		w.op = ppe_pkg::OP_FINISH;
		queue_word(w);
		for (int i = 0; i < 3; i++) begin
			w = noise_word();
			w.op = OP_FIRST_UNUSED + 3'(i);
			queue_word(w);
		end
		w = '0;
		w.op = ppe_pkg::OP_HEADER;
		w.vol = 31'h0002_0000;
		w.wvol = 31'h0001_0000;
		w.dil = 32'hFFFF_8000;
		w.a = {3{32'h8000_0000}};
		queue_word(w);
		w.op = ppe_pkg::OP_VEL;
		w.a = {32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF};
		queue_word(w);
		w.op = ppe_pkg::OP_BOND;
		w.a = {3{32'h7FFF_FFFF}};
		w.b = {3{32'h0000_8000}};
		queue_word(w);
		w.a = {3{32'h8000_0001}};
		w.vol = '0;
		queue_word(w);
		w.op = ppe_pkg::OP_FINISH;
		queue_word(w);
		w.op = ppe_pkg::OP_CLEAR;
		queue_word(w);
		w.op = ppe_pkg::OP_FINISH;
		queue_word(w);
	endtask

	initial begin
		int count, added;
		logic [31:0] k_val, mu_val, rho_val;
		bulk_k = ppe_pkg::MOD_RESET;
		shear_mu = ppe_pkg::MOD_RESET;
		density_rho = ppe_pkg::MOD_RESET;
		for (int k = 0; k < 3; k++) begin
			ref_pos[k] = 0;
			cur_pos[k] = 0;
		end
		pt_volume = 0;
		pt_weight = 0;
		pt_theta = 0;
		v_sq = 0;
		bond_sum = 0;
		strain_acc = 0;
		kinetic_acc = 0;
		ovf_flag = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_settle();
			case (ph)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 49;
					k_val = 32'h0003_0000;
					mu_val = 32'h0000_8000;
					rho_val = 32'h0002_0000;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 24;
					k_val = '1;
					mu_val = '1;
					rho_val = '1;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					k_val = '0;
					mu_val = '0;
					rho_val = '0;
				end
				default: begin
					k_val = $urandom;
					mu_val = $urandom_range(32'h0010_0000);
					rho_val = $urandom_range(32'h0010_0000);
				end
			endcase
			write_reg(ppe_pkg::REG_BULK, k_val);
			write_reg(ppe_pkg::REG_SHEAR, mu_val);
			write_reg(ppe_pkg::REG_DENSITY, rho_val);
			if (ph == 0)
				add_directed();
			count = 0;
			while (count < 150) begin
				if ($urandom_range(9) == 0) begin
					queue_word(noise_word());
					count++;
				end else begin
					add_point(added);
					count += added;
				end
			end
		end
		drain_and_settle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: peridynamic_point_energy.f
rtl/ppe_pkg.sv
rtl/ppe_mul.sv
rtl/ppe_sqrt.sv
rtl/ppe_div.sv
rtl/peridynamic_point_energy.sv
rtl/ppe_check.sv
verif/peridynamic_point_energy_test.sv
